// ===== rtl/nisp_pkg.sv =====
// Package for the nullomer index stream parser: payload types, phase and status codes.
package nisp_pkg;

    localparam int HEADER_SKIP_BYTES = 6;
    localparam int MAX_FIELD_BYTES   = 8;
    localparam int HDR_FIELD_BYTES   = 6;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_HDR    = 3'd1,
        PH_PREFIX = 3'd2,
        PH_COUNT  = 3'd3,
        PH_SUFFIX = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    localparam t_phase PH_RESET = (HEADER_SKIP_BYTES == 0) ? PH_HDR : PH_SKIP;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [63:0] index_value;
        logic        index_valid;
        logic [1:0]  stream_status;
        logic [15:0] word_length;
    } t_out;

endpackage

// ===== rtl/nullomer_index_stream_parser_core.sv =====
// Nullomer index stream parser: byte-wise header/group parser with a two-entry output buffer.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in: byte, end flag)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out: index, status, k)
//
// One byte per cycle while o_in_ready is high; each accepted beat is parsed in the cycle it is taken and its
// result, if any, is registered the same edge.
// Synchronous active-low reset returns the parser to the header skip phase.
// A skid register holds one result while the output stalls; o_in_ready drops only
// when both output registers are full.
// Bytes after completion or error are accepted and dropped.
module nullomer_index_stream_parser_core
    import nisp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_phase      r_phase, n_phase;
    t_status     r_fin, n_fin;
    logic [3:0]  r_bp, n_bp;
    logic [15:0] r_k, n_k;
    logic [15:0] r_hk, n_hk;
    logic [7:0]  r_field, n_field;
    logic [7:0]  r_counter, n_counter;
    logic [63:0] r_prefix, n_prefix;
    logic [63:0] r_suffix, n_suffix;
    logic [63:0] r_rem, n_rem;

    logic        r_out_v;
    t_out        r_out;
    logic        r_skid_v;
    t_out        r_skid;

    logic        in_acc;
    logic        emit;
    logic [63:0] idx;
    logic [63:0] byte_sh;
    logic        have_res;
    t_out        res;

    function automatic logic [63:0] combine(input logic [15:0] k, input logic [15:0] hk,
                                            input logic [63:0] pre, input logic [63:0] suf);
        logic [16:0] d;
        d = {1'b0, k} - {1'b0, hk};
        if (d[16] || (d[15:0] >= 16'd32))
            return suf;
        return (pre << {d[4:0], 1'b0}) | suf;
    endfunction

    assign o_in_ready = !r_skid_v;
    assign in_acc     = i_in_valid && o_in_ready;
    assign byte_sh    = {56'd0, i_in_data.data_byte} << {r_bp[2:0], 3'b000};

    // parser next state
    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_bp      = r_bp;
        n_k       = r_k;
        n_hk      = r_hk;
        n_field   = r_field;
        n_counter = r_counter;
        n_prefix  = r_prefix;
        n_suffix  = r_suffix;
        n_rem     = r_rem;
        emit      = 1'b0;
        idx       = 64'd0;
        if (in_acc && (r_fin == ST_RUN)) begin
            unique case (r_phase)
                PH_SKIP: begin
                    // skip count lives in the suffix counter
                    n_rem = r_rem + 64'd1;
                    if (n_rem >= 64'(HEADER_SKIP_BYTES)) begin
                        n_phase = PH_HDR;
                        n_rem   = 64'd0;
                        n_bp    = 4'd0;
                    end
                end
                PH_HDR: begin
                    case (r_bp)
                        4'd0:    n_k       = {r_k[15:8], i_in_data.data_byte};
                        4'd1:    n_k       = {i_in_data.data_byte, r_k[7:0]};
                        4'd2:    n_hk      = {r_hk[15:8], i_in_data.data_byte};
                        4'd3:    n_hk      = {i_in_data.data_byte, r_hk[7:0]};
                        4'd4:    n_field   = i_in_data.data_byte;
                        default: n_counter = i_in_data.data_byte;
                    endcase
                    n_bp = r_bp + 4'd1;
                    if (n_bp >= 4'(HDR_FIELD_BYTES)) begin
                        n_bp = 4'd0;
                        if (n_field == 8'd0) begin
                            n_fin = ST_DONE;
                        end else if ((n_field > 8'(MAX_FIELD_BYTES)) ||
                                     (n_counter > 8'(MAX_FIELD_BYTES))) begin
                            n_fin = ST_ERR;
                        end else if (n_counter == 8'd0) begin
                            n_fin = ST_DONE;
                        end else begin
                            n_phase  = PH_PREFIX;
                            n_prefix = 64'd0;
                        end
                    end
                end
                PH_PREFIX: begin
                    n_prefix = r_prefix | byte_sh;
                    n_bp     = r_bp + 4'd1;
                    if ({4'd0, n_bp} >= r_field) begin
                        n_phase = PH_COUNT;
                        n_bp    = 4'd0;
                        n_rem   = 64'd0;
                    end
                end
                PH_COUNT: begin
                    n_rem = r_rem | byte_sh;
                    n_bp  = r_bp + 4'd1;
                    if ({4'd0, n_bp} >= r_counter) begin
                        n_bp = 4'd0;
                        if (n_rem == 64'd0) begin
                            n_phase  = PH_PREFIX;
                            n_prefix = 64'd0;
                        end else begin
                            n_phase  = PH_SUFFIX;
                            n_suffix = 64'd0;
                        end
                    end
                end
                PH_SUFFIX: begin
                    n_suffix = r_suffix | byte_sh;
                    n_bp     = r_bp + 4'd1;
                    if ({4'd0, n_bp} >= r_field) begin
                        idx      = combine(r_k, r_hk, r_prefix, n_suffix);
                        emit     = 1'b1;
                        n_bp     = 4'd0;
                        n_suffix = 64'd0;
                        n_rem    = r_rem - 64'd1;
                        if (n_rem == 64'd0) begin
                            n_phase  = PH_PREFIX;
                            n_prefix = 64'd0;
                        end
                    end
                end
                default: ;
            endcase
            // end of stream is judged against the phase after this byte
            if (i_in_data.end_of_stream && (n_fin == ST_RUN)) begin
                if ((n_phase == PH_SKIP) || (n_phase == PH_HDR) || (n_phase == PH_SUFFIX))
                    n_fin = ST_ERR;
                else
                    n_fin = ST_DONE;
            end
        end
    end

    // result beat
    always_comb begin
        have_res          = emit || (n_fin != r_fin);
        res.index_value   = idx;
        res.index_valid   = emit;
        res.stream_status = n_fin;
        res.word_length   = n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RESET;
            r_fin     <= ST_RUN;
            r_bp      <= 4'd0;
            r_k       <= 16'd0;
            r_hk      <= 16'd0;
            r_field   <= 8'd0;
            r_counter <= 8'd0;
            r_prefix  <= 64'd0;
            r_suffix  <= 64'd0;
            r_rem     <= 64'd0;
            r_out_v   <= 1'b0;
            r_skid_v  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_fin     <= n_fin;
            r_bp      <= n_bp;
            r_k       <= n_k;
            r_hk      <= n_hk;
            r_field   <= n_field;
            r_counter <= n_counter;
            r_prefix  <= n_prefix;
            r_suffix  <= n_suffix;
            r_rem     <= n_rem;
            if (!r_out_v || i_out_ready) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v  <= have_res;
                end
            end else if (have_res) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            if (r_skid_v)
                r_out <= r_skid;
            else
                r_out <= res;
        end else if (have_res) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while output register is empty");

    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.index_valid) |->
            (o_out_data.stream_status != ST_RUN))
        else $error("result beat with neither index nor status change");

    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin != ST_RUN) |=> $stable(r_fin))
        else $error("stream status changed after completion");

    a_suffix_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SUFFIX) |-> (r_rem != 64'd0))
        else $error("suffix phase with no suffixes owed");

endmodule

// ===== tb/nullomer_index_stream_parser_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nullomer index stream parser: one file stream, scoreboarded beats.
module nullomer_index_stream_parser_core_tb
    import nisp_pkg::*;
();

    localparam int RANDOM_BYTES = 888;
    localparam int NO_EOS       = -1;
    localparam int STALL_CYCLES = 400;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    nullomer_index_stream_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // parser state mirror
    t_phase      ph        = PH_RESET;
    logic [3:0]  pos       = '0;
    logic [15:0] k_reg     = '0;
    logic [15:0] hk_reg    = '0;
    logic [7:0]  fld_bytes = '0;
    logic [7:0]  cnt_bytes = '0;
    logic [63:0] pfx       = '0;
    logic [63:0] sfx       = '0;
    logic [63:0] owed      = '0;
    t_status     status    = ST_RUN;

    t_out pending_results[$];
    t_out want;
    int   mismatches   = 0;
    int   bytes_sent   = 0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   stall_request = 0;
    int   stall_left    = 0;
    int   hdr_fb;
    int   hdr_cb;

    function automatic void start_group();
        ph  = PH_PREFIX;
        pos = '0;
        pfx = '0;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eos);
        logic [63:0] bw;
        logic [5:0]  sh;
        logic        emit;
        logic [63:0] idx;
        t_status     was;
        t_out        r;
        int          d;
        bw   = {56'd0, b};
        sh   = {pos[2:0], 3'b000};
        emit = 1'b0;
        idx  = '0;
        was  = status;
        if (status != ST_RUN) return;
        case (ph)
            PH_SKIP: begin
                owed = owed + 64'd1;
                if (owed >= HEADER_SKIP_BYTES) begin
                    ph   = PH_HDR;
                    owed = '0;
                    pos  = '0;
                end
            end
            PH_HDR: begin
                case (pos)
                    4'd0: k_reg[7:0]   = b;
                    4'd1: k_reg[15:8]  = b;
                    4'd2: hk_reg[7:0]  = b;
                    4'd3: hk_reg[15:8] = b;
                    4'd4: fld_bytes    = b;
                    default: cnt_bytes = b;
                endcase
                pos = pos + 4'd1;
                if (pos >= HDR_FIELD_BYTES) begin
                    pos = '0;
                    if (fld_bytes == 0)
                        status = ST_DONE;
                    else if (fld_bytes > MAX_FIELD_BYTES || cnt_bytes > MAX_FIELD_BYTES)
                        status = ST_ERR;
                    else if (cnt_bytes == 0)
                        status = ST_DONE;
                    else
                        start_group();
                end
            end
            PH_PREFIX: begin
                pfx = pfx | (bw << sh);
                pos = pos + 4'd1;
                if (pos >= fld_bytes) begin
                    ph   = PH_COUNT;
                    pos  = '0;
                    owed = '0;
                end
            end
            PH_COUNT: begin
                owed = owed | (bw << sh);
                pos  = pos + 4'd1;
                if (pos >= cnt_bytes) begin
                    pos = '0;
                    if (owed == 0) begin
                        start_group();
                    end else begin
                        ph  = PH_SUFFIX;
                        sfx = '0;
                    end
                end
            end
            default: begin
                sfx = sfx | (bw << sh);
                pos = pos + 4'd1;
                if (pos >= fld_bytes) begin
                    d = int'(k_reg) - int'(hk_reg);
                    // shift of 64 or more, or k below half_k: suffix alone
                    idx  = (d < 0 || d >= 32) ? sfx : ((pfx << (2 * d)) | sfx);
                    emit = 1'b1;
                    pos  = '0;
                    sfx  = '0;
                    owed = owed - 64'd1;
                    if (owed == 0) start_group();
                end
            end
        endcase
        if (eos && status == ST_RUN) begin
            if (ph == PH_SKIP || ph == PH_HDR || ph == PH_SUFFIX)
                status = ST_ERR;
            else
                status = ST_DONE;
        end
        if (emit || status != was) begin
            r.index_value   = emit ? idx : 64'd0;
            r.index_valid   = emit;
            r.stream_status = status;
            r.word_length   = k_reg;
            pending_results.push_back(r);
        end
    endtask

    function automatic logic [63:0] field_mask(input int nbytes);
        return (nbytes >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8 * nbytes)) - 64'd1);
    endfunction

    function automatic logic [63:0] rand_field(input int nbytes);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 64'd0;
        if (r == 1) return field_mask(nbytes);
        return {$urandom, $urandom} & field_mask(nbytes);
    endfunction

    // called and returns at a falling edge; valid stays high across back-to-back beats
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, end_of_stream: eos};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_byte(b, eos);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_value(input logic [63:0] value, input int nbytes, input int eos_at);
        for (int i = 0; i < nbytes; i++)
            send_byte(value[8*i +: 8], i == eos_at);
    endtask

    task automatic send_random_group();
        logic [63:0] count;
        int          r;
        send_value(rand_field(hdr_fb), hdr_fb, NO_EOS);
        r = $urandom_range(0, 99);
        if (r < 10)
            count = 64'd0;
        else if (r < 95)
            count = 64'($urandom_range(1, 6));
        else
            count = 64'($urandom_range(7, 40));
        send_value(count, hdr_cb, NO_EOS);
        for (int i = 0; i < count; i++)
            send_value(rand_field(hdr_fb), hdr_fb, NO_EOS);
    endtask

    task automatic test_header();
        int d;
        int hk;
        int r;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (HEADER_SKIP_BYTES - 2) send_byte(8'($urandom), 1'b0);
        case ($urandom_range(0, 5))
            0: d = 0;
            1: d = 31;                                  // widest legal shift
            2: d = $urandom_range(32, 2000);            // shift out of range
            3: d = -int'($urandom_range(1, 2000));      // k below half_k
            default: d = $urandom_range(1, 30);
        endcase
        if (d >= 0)
            hk = $urandom_range(0, 65535 - d);
        else
            hk = $urandom_range(-d, 65535);
        send_value(64'(hk + d), 2, NO_EOS);
        send_value(64'(hk), 2, NO_EOS);
        r = $urandom_range(0, 3);
        hdr_fb = (r == 0) ? 1 : (r == 1) ? MAX_FIELD_BYTES : $urandom_range(1, MAX_FIELD_BYTES);
        r = $urandom_range(0, 3);
        hdr_cb = (r == 0) ? 1 : (r == 1) ? MAX_FIELD_BYTES : $urandom_range(1, MAX_FIELD_BYTES);
        send_byte(8'(hdr_fb), 1'b0);
        send_byte(8'(hdr_cb), 1'b0);
    endtask

    task automatic test_directed_groups();
        // zero counter: no index, next group starts
        send_value(field_mask(hdr_fb), hdr_fb, NO_EOS);
        send_value(64'd0, hdr_cb, NO_EOS);
        send_value(64'd0, hdr_fb, NO_EOS);
        send_value(64'd1, hdr_cb, NO_EOS);
        send_value(field_mask(hdr_fb), hdr_fb, NO_EOS);
        send_value(field_mask(hdr_fb), hdr_fb, NO_EOS);
        send_value(64'd2, hdr_cb, NO_EOS);
        send_value(64'd0, hdr_fb, NO_EOS);
        send_value(field_mask(hdr_fb), hdr_fb, NO_EOS);
    endtask

    task automatic test_random_groups(input int n_bytes, input int src_pct, input int snk_pct);
        int target;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) send_random_group();
    endtask

    task automatic test_output_stall();
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        stall_request = STALL_CYCLES;
        send_value(rand_field(hdr_fb), hdr_fb, NO_EOS);
        send_value(64'd24, hdr_cb, NO_EOS);
        repeat (24) send_value(rand_field(hdr_fb), hdr_fb, NO_EOS);
        send_random_group();
    endtask

    task automatic test_stream_end();
        logic [63:0] count;
        int          c;
        send_value(rand_field(hdr_fb), hdr_fb, NO_EOS);
        case ($urandom_range(0, 3))
            0: begin    // end on the last suffix of a group: index and completion together
                c = $urandom_range(1, 3);
                send_value(64'(c), hdr_cb, NO_EOS);
                for (int i = 0; i < c; i++)
                    send_value(rand_field(hdr_fb), hdr_fb, (i == c - 1) ? hdr_fb - 1 : NO_EOS);
            end
            1: begin    // end inside the next prefix
                send_value(64'd0, hdr_cb, NO_EOS);
                send_value(rand_field(hdr_fb), hdr_fb, $urandom_range(0, hdr_fb - 1));
            end
            2: begin    // end inside a counter
                send_value(64'($urandom_range(0, 3)), hdr_cb, $urandom_range(0, hdr_cb - 1));
            end
            default: begin  // end inside a suffix run, counter of at least two with random high bytes
                count = ({$urandom, $urandom} & field_mask(hdr_cb)) | 64'd2;
                send_value(count, hdr_cb, NO_EOS);
                send_value(rand_field(hdr_fb), hdr_fb, NO_EOS);
                send_value(rand_field(hdr_fb), hdr_fb, $urandom_range(0, hdr_fb - 1));
            end
        endcase
        // bytes after the end are dropped without a beat
        repeat (6) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    always @(negedge i_clk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected beat: index_value %h status %0d",
                       o_out_data.index_value, o_out_data.stream_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.index_value !== want.index_value) begin
                    $error("index_value: expected %h, got %h",
                           want.index_value, o_out_data.index_value);
                    mismatches++;
                end
                if (o_out_data.index_valid !== want.index_valid) begin
                    $error("index_valid: expected %0d, got %0d",
                           want.index_valid, o_out_data.index_valid);
                    mismatches++;
                end
                if (o_out_data.stream_status !== want.stream_status) begin
                    $error("stream_status: expected %0d, got %0d",
                           want.stream_status, o_out_data.stream_status);
                    mismatches++;
                end
                if (o_out_data.word_length !== want.word_length) begin
                    $error("word_length: expected %0d, got %0d",
                           want.word_length, o_out_data.word_length);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_header();
        test_directed_groups();
        test_random_groups(RANDOM_BYTES / 3, 37, 77);
        test_random_groups(RANDOM_BYTES / 3, 77, 37);
        test_random_groups(RANDOM_BYTES / 3, 0, 0);
        test_output_stall();
        test_stream_end();
        i_in_valid <= 1'b0;
        snk_idle_pct = 0;
        for (int w = 0; w < 20000 && pending_results.size() != 0; w++) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected beats never arrived", pending_results.size());
            mismatches++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
